>>> hw/rtl/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared widths, codes and controller/datapath handshake types for the
// priority message queue.
// ----------------------------------------------------------------------------
package pmq_pkg;

  // default sizing
  localparam int SLOTS_DEF         = 16;
  localparam int PAYLOAD_BYTES_DEF = 8;

  // field widths
  localparam int PRIO_W     = 32;
  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 4;
  localparam int DATA_W     = 64;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int MAX_MSG_W  = 5;
  localparam int MAX_LEN_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // reset values of the configuration registers
  localparam logic [MAX_MSG_W-1:0] MAX_MSG_RST = 5'd16;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 4'd8;

  // item command
  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_RECV = 1'b1
  } command_t;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_MESSAGES = 1'b0,
    CFG_MAX_LENGTH   = 1'b1
  } cfg_index_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the input beat, restart the scan
    logic issue;   // read the next slot into the scan pipeline
    logic commit;  // update slots and load the result register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip_scan;  // send to a full queue, no scan needed
    logic scan_last;  // the slot being issued is the last one
    logic pipe_busy;  // scan pipeline still holds slots
    logic out_hold;   // result register full and not being taken
  } ctl_status_t;

endpackage

>>> hw/rtl/pmq_if.sv
// ----------------------------------------------------------------------------
// pmq_in_if / pmq_out_if
// Valid/ready channels carrying request beats into and result beats out of
// the priority message queue.
// ----------------------------------------------------------------------------
interface pmq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [pmq_pkg::PRIO_W-1:0]  priority_req;
  logic [pmq_pkg::DATA_W-1:0]  payload_in;
  logic [pmq_pkg::LEN_W-1:0]   length_in;
  logic [pmq_pkg::LEN_W-1:0]   receive_limit;

  modport source (
    output valid, command, priority_req, payload_in, length_in, receive_limit,
    input  ready
  );
  modport sink (
    input  valid, command, priority_req, payload_in, length_in, receive_limit,
    output ready
  );
endinterface

interface pmq_out_if;
  logic                         valid;
  logic                         ready;
  logic [pmq_pkg::STATUS_W-1:0] status;
  logic [pmq_pkg::LEN_W-1:0]    length_out;
  logic [pmq_pkg::DATA_W-1:0]   payload_out;
  logic [pmq_pkg::PRIO_W-1:0]   priority_out;
  logic [pmq_pkg::COUNT_W-1:0]  message_count;

  modport source (
    output valid, status, length_out, payload_out, priority_out, message_count,
    input  ready
  );
  modport sink (
    input  valid, status, length_out, payload_out, priority_out, message_count,
    output ready
  );
endinterface

>>> hw/rtl/pmq_ram.sv
// ----------------------------------------------------------------------------
// pmq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/pmq_ctrl.sv
// ----------------------------------------------------------------------------
// pmq_ctrl
// Sequencer for the priority message queue: accepts a beat, walks the slot
// scan, waits for the scan pipeline to drain and commits the result.
// ----------------------------------------------------------------------------
module pmq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pmq_pkg::ctl_status_t st,
  output pmq_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.skip_scan) begin
          state_nxt = ST_COMMIT;
        end else begin
          cmd.issue = 1'b1;
          if (st.scan_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!st.pipe_busy) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!st.out_hold) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/pmq_dpath.sv
// ----------------------------------------------------------------------------
// pmq_dpath
// Datapath of the priority message queue: slot RAM, valid bits, counters,
// a three-stage scan pipeline with one priority/age comparator, the commit
// logic and the result register.
// ----------------------------------------------------------------------------
module pmq_dpath #(
  parameter int SLOTS         = pmq_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BYTES = pmq_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [pmq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmq_pkg::CFG_DATA_W-1:0]  cfg_data,
  // request payload
  input  logic                            in_command,
  input  logic [pmq_pkg::PRIO_W-1:0]      in_priority_req,
  input  logic [pmq_pkg::DATA_W-1:0]      in_payload_in,
  input  logic [pmq_pkg::LEN_W-1:0]       in_length_in,
  input  logic [pmq_pkg::LEN_W-1:0]       in_receive_limit,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pmq_pkg::STATUS_W-1:0]    out_status,
  output logic [pmq_pkg::LEN_W-1:0]       out_length_out,
  output logic [pmq_pkg::DATA_W-1:0]      out_payload_out,
  output logic [pmq_pkg::PRIO_W-1:0]      out_priority_out,
  output logic [pmq_pkg::COUNT_W-1:0]     out_message_count,
  // controller
  input  pmq_pkg::ctl_cmd_t               cmd,
  output pmq_pkg::ctl_status_t            st
);

  localparam int PRIO_W  = pmq_pkg::PRIO_W;
  localparam int SEQ_W   = pmq_pkg::SEQ_W;
  localparam int LEN_W   = pmq_pkg::LEN_W;
  localparam int DATA_W  = pmq_pkg::DATA_W;
  localparam int COUNT_W = pmq_pkg::COUNT_W;
  localparam int PW      = 8 * PAYLOAD_BYTES;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int REC_W   = PRIO_W + SEQ_W + LEN_W + PW;

  // byte mask covering the low n bytes of the stored word
  function automatic logic [PW-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [PW-1:0] m;
    m = '0;
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      if (LEN_W'(b) < n) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // configuration registers
  logic [pmq_pkg::MAX_MSG_W-1:0] cfg_max_msgs_r;
  logic [pmq_pkg::MAX_LEN_W-1:0] cfg_max_len_r;

  // captured item
  pmq_pkg::command_t             item_cmd_r;
  logic [PRIO_W-1:0]             item_prio_r;
  logic [PW-1:0]                 item_pay_r;
  logic [LEN_W-1:0]              item_len_r;
  logic [LEN_W-1:0]              item_limit_r;

  // queue state
  logic [SLOTS-1:0]              slot_vld_r, slot_vld_nxt;
  logic [CNT_W-1:0]              held_r, held_nxt;
  logic [SEQ_W-1:0]              next_seq_r, next_seq_nxt;

  // scan pipeline
  logic [IDX_W-1:0]              scan_idx_r;
  logic                          s1_v_r, s1_vld_r;
  logic [IDX_W-1:0]              s1_idx_r;
  logic [REC_W-1:0]              rd_data;
  logic                          s2_v_r, s2_vld_r;
  logic [IDX_W-1:0]              s2_idx_r;
  logic [PRIO_W-1:0]             s2_prio_r;
  logic [SEQ_W-1:0]              s2_age_r;
  logic [LEN_W-1:0]              s2_len_r;
  logic [PW-1:0]                 s2_pay_r;

  // scan results
  logic                          best_found_r;
  logic [IDX_W-1:0]              best_idx_r;
  logic [PRIO_W-1:0]             best_prio_r;
  logic [SEQ_W-1:0]              best_age_r;
  logic [LEN_W-1:0]              best_len_r;
  logic [PW-1:0]                 best_pay_r;
  logic                          free_found_r;
  logic [IDX_W-1:0]              free_idx_r;

  // result register
  logic                          out_valid_r;
  pmq_pkg::status_t              out_status_r, out_status_nxt;
  logic [LEN_W-1:0]              out_len_r, out_len_nxt;
  logic [PW-1:0]                 out_pay_r, out_pay_nxt;
  logic [PRIO_W-1:0]             out_prio_r, out_prio_nxt;
  logic [COUNT_W-1:0]            out_count_r;

  // effective limits and derived values
  logic [CNT_W-1:0]              eff_msgs;
  logic [LEN_W-1:0]              eff_len;
  logic                          queue_full;
  logic [LEN_W-1:0]              store_len;
  logic [LEN_W-1:0]              recv_len;
  logic                          cand_better;
  logic                          ram_we;
  logic [REC_W-1:0]              ram_wdata;

  // out-of-range register values fall back to the full size
  always_comb begin
    if (cfg_max_msgs_r == '0 || 32'(cfg_max_msgs_r) > SLOTS) begin
      eff_msgs = CNT_W'(SLOTS);
    end else begin
      eff_msgs = CNT_W'(cfg_max_msgs_r);
    end
    if (cfg_max_len_r == '0 || 32'(cfg_max_len_r) > PAYLOAD_BYTES) begin
      eff_len = LEN_W'(PAYLOAD_BYTES);
    end else begin
      eff_len = cfg_max_len_r;
    end
  end

  assign queue_full = held_r >= eff_msgs;
  assign store_len  = (item_len_r > eff_len) ? eff_len : item_len_r;
  assign recv_len   = (best_len_r > item_limit_r) ? item_limit_r : best_len_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_max_msgs_r <= pmq_pkg::MAX_MSG_RST;
      cfg_max_len_r  <= pmq_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (pmq_pkg::cfg_index_t'(cfg_index))
        pmq_pkg::CFG_MAX_MESSAGES: cfg_max_msgs_r <= cfg_data;
        pmq_pkg::CFG_MAX_LENGTH:   cfg_max_len_r  <= cfg_data[pmq_pkg::MAX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the request beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd_r   <= pmq_pkg::command_t'(in_command);
      item_prio_r  <= in_priority_req;
      item_pay_r   <= in_payload_in[PW-1:0];
      item_len_r   <= in_length_in;
      item_limit_r <= in_receive_limit;
    end
  end

  // slot record store
  pmq_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (free_idx_r),
    .wdata   (ram_wdata),
    .raddr   (scan_idx_r),
    .rd_data (rd_data)
  );

  // scan address and first pipeline stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      s1_v_r     <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (cmd.issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      s1_v_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_vld_r <= slot_vld_r[scan_idx_r];
    s1_idx_r <= scan_idx_r;
  end

  // second stage: unpack the record and work out its age
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_vld_r  <= s1_vld_r;
    s2_idx_r  <= s1_idx_r;
    s2_prio_r <= rd_data[REC_W-1 -: PRIO_W];
    s2_age_r  <= next_seq_r - rd_data[REC_W-PRIO_W-1 -: SEQ_W];
    s2_len_r  <= rd_data[PW +: LEN_W];
    s2_pay_r  <= rd_data[PW-1:0];
  end

  // third stage: compare against the best so far, note the first free slot
  assign cand_better = s2_vld_r &&
                       (!best_found_r || s2_prio_r > best_prio_r ||
                        (s2_prio_r == best_prio_r && s2_age_r > best_age_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.load) begin
      best_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else if (s2_v_r) begin
      if (cand_better) begin
        best_found_r <= 1'b1;
      end
      if (!s2_vld_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && cand_better) begin
      best_idx_r  <= s2_idx_r;
      best_prio_r <= s2_prio_r;
      best_age_r  <= s2_age_r;
      best_len_r  <= s2_len_r;
      best_pay_r  <= s2_pay_r;
    end
    if (s2_v_r && !s2_vld_r && !free_found_r) begin
      free_idx_r <= s2_idx_r;
    end
  end

  // commit: slot update and result fields
  always_comb begin
    slot_vld_nxt   = slot_vld_r;
    held_nxt       = held_r;
    next_seq_nxt   = next_seq_r;
    ram_we         = 1'b0;
    ram_wdata      = {item_prio_r, next_seq_r, store_len, item_pay_r & byte_mask(store_len)};
    out_status_nxt = pmq_pkg::STATUS_DONE;
    out_len_nxt    = '0;
    out_pay_nxt    = '0;
    out_prio_nxt   = '0;
    case (item_cmd_r)
      pmq_pkg::CMD_SEND: begin
        if (queue_full || !free_found_r) begin
          out_status_nxt = pmq_pkg::STATUS_FULL;
        end else begin
          ram_we                   = cmd.commit;
          slot_vld_nxt[free_idx_r] = 1'b1;
          held_nxt                 = held_r + 1'b1;
          next_seq_nxt             = next_seq_r + 1'b1;
          out_len_nxt              = store_len;
        end
      end
      default: begin
        if (!best_found_r) begin
          out_status_nxt = pmq_pkg::STATUS_EMPTY;
        end else begin
          slot_vld_nxt[best_idx_r] = 1'b0;
          if (held_r != '0) begin
            held_nxt = held_r - 1'b1;
          end
          out_len_nxt  = recv_len;
          out_pay_nxt  = best_pay_r & byte_mask(recv_len);
          out_prio_nxt = best_prio_r;
        end
      end
    endcase
  end

  // queue state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      held_r     <= '0;
      next_seq_r <= '0;
    end else if (cmd.commit) begin
      slot_vld_r <= slot_vld_nxt;
      held_r     <= held_nxt;
      next_seq_r <= next_seq_nxt;
    end
  end

  // result register, loaded on commit and emptied when the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= out_status_nxt;
      out_len_r    <= out_len_nxt;
      out_pay_r    <= out_pay_nxt;
      out_prio_r   <= out_prio_nxt;
      out_count_r  <= COUNT_W'(held_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_length_out    = out_len_r;
  assign out_payload_out   = DATA_W'(out_pay_r);
  assign out_priority_out  = out_prio_r;
  assign out_message_count = out_count_r;

  // status toward the controller
  assign st.skip_scan = (item_cmd_r == pmq_pkg::CMD_SEND) && queue_full;
  assign st.scan_last = scan_idx_r == IDX_W'(SLOTS - 1);
  assign st.pipe_busy = s1_v_r | s2_v_r;
  assign st.out_hold  = out_valid_r && !out_ready;

`ifndef SYNTHESIS
  // held count tracks the number of occupied slots
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_vld_r) == int'(held_r))
    else $error("held count differs from occupied slots");

  // nothing is committed while slots are still in the scan pipeline
  a_commit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(s1_v_r || s2_v_r))
    else $error("commit with scan pipeline busy");

  // a successful receive frees the slot it returned
  a_recv_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && item_cmd_r == pmq_pkg::CMD_RECV && best_found_r)
      |=> !slot_vld_r[$past(best_idx_r)])
    else $error("received slot still marked valid");

  // a result only appears after a commit
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result beat without commit");
`endif

endmodule

>>> hw/rtl/priority_message_queue.sv
// ----------------------------------------------------------------------------
// priority_message_queue
// Bounded priority message queue: send stores a message, receive returns the
// highest-priority, oldest message.
// ----------------------------------------------------------------------------
// One request beat is handled at a time. A send or receive holds the block
// through the accept, a walk in which a single comparator reads the slot
// RAM one slot at a time through its one read port, the drain of the scan
// pipeline and the commit. A send to a full queue skips the walk. The result
// sits in an output register, so the next request is taken while the previous
// result waits; a commit stalls only if that register is still occupied and
// not being taken. No clearing pass follows reset.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the queue is idle, as the block itself does
// not enforce it.
// ----------------------------------------------------------------------------
module priority_message_queue #(
  parameter int SLOTS         = pmq_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BYTES = pmq_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pmq_in_if.sink                         in_ch,
  pmq_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [pmq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmq_pkg::CFG_DATA_W-1:0] cfg_data
);

  pmq_pkg::ctl_cmd_t    cmd;
  pmq_pkg::ctl_status_t st;
  logic                 in_ready;

  // sequencer
  pmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // datapath
  pmq_dpath #(
    .SLOTS         (SLOTS),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_command        (in_ch.command),
    .in_priority_req   (in_ch.priority_req),
    .in_payload_in     (in_ch.payload_in),
    .in_length_in      (in_ch.length_in),
    .in_receive_limit  (in_ch.receive_limit),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_length_out    (out_ch.length_out),
    .out_payload_out   (out_ch.payload_out),
    .out_priority_out  (out_ch.priority_out),
    .out_message_count (out_ch.message_count),
    .cmd               (cmd),
    .st                (st)
  );

endmodule

>>> tb/priority_message_queue_test.sv
// ----------------------------------------------------------------------------
// priority_message_queue_test
// Self-checking test of the priority message queue. Request beats are driven
// with random gaps and every result beat is compared against a cycle-free
// mirror of the queue: slot table, ages, truncation and the live settings.
// A directed opener covers empty, full, ties, truncation and receive limits;
// random phases then run under several register settings, extremes included.
// ----------------------------------------------------------------------------

// one request beat as the sender sees it
typedef struct {
  pmq_pkg::command_t              command;
  logic [pmq_pkg::PRIO_W-1:0]     prio;
  logic [pmq_pkg::DATA_W-1:0]     payload;
  logic [pmq_pkg::LEN_W-1:0]      length;
  logic [pmq_pkg::LEN_W-1:0]      limit;
} request_t;

// one result beat
typedef struct {
  pmq_pkg::status_t               status;
  logic [pmq_pkg::LEN_W-1:0]      length;
  logic [pmq_pkg::DATA_W-1:0]     payload;
  logic [pmq_pkg::PRIO_W-1:0]     prio;
  logic [pmq_pkg::COUNT_W-1:0]    count;
} result_t;

// mirror of the queue plus the results it still owes
class pmq_scoreboard;
  logic [pmq_pkg::MAX_MSG_W-1:0] max_messages;
  logic [pmq_pkg::MAX_LEN_W-1:0] max_length;
  bit                            slot_used  [pmq_pkg::SLOTS_DEF];
  logic [pmq_pkg::PRIO_W-1:0]    slot_prio  [pmq_pkg::SLOTS_DEF];
  logic [pmq_pkg::SEQ_W-1:0]     slot_stamp [pmq_pkg::SLOTS_DEF];
  logic [pmq_pkg::LEN_W-1:0]     slot_len   [pmq_pkg::SLOTS_DEF];
  logic [pmq_pkg::DATA_W-1:0]    slot_data  [pmq_pkg::SLOTS_DEF];
  int                            held;
  logic [pmq_pkg::SEQ_W-1:0]     next_stamp;
  result_t                       due_results[$];
  int                            errors;

  function new();
    max_messages = pmq_pkg::MAX_MSG_RST;
    max_length   = pmq_pkg::MAX_LEN_RST;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    held       = 0;
    next_stamp = '0;
    errors     = 0;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  function void write_reg(pmq_pkg::cfg_index_t idx, logic [pmq_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      pmq_pkg::CFG_MAX_MESSAGES: max_messages = data[pmq_pkg::MAX_MSG_W-1:0];
      pmq_pkg::CFG_MAX_LENGTH:   max_length   = data[pmq_pkg::MAX_LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // zero every byte at or above n
  static function logic [pmq_pkg::DATA_W-1:0] keep_bytes(logic [pmq_pkg::DATA_W-1:0] w,
                                                         int n);
    if (n >= pmq_pkg::PAYLOAD_BYTES_DEF) return w;
    return w & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  // apply one accepted request beat, queue the result it must produce
  function void note_request(request_t req);
    result_t                   res;
    int                        cap_msgs;
    int                        cap_len;
    int                        slot;
    int                        n;
    logic [pmq_pkg::SEQ_W-1:0] age;
    logic [pmq_pkg::SEQ_W-1:0] best_age;
    res.status  = pmq_pkg::STATUS_DONE;
    res.length  = '0;
    res.payload = '0;
    res.prio    = '0;
    cap_msgs = (max_messages == 0 || int'(max_messages) > pmq_pkg::SLOTS_DEF) ?
               pmq_pkg::SLOTS_DEF : int'(max_messages);
    cap_len  = (max_length == 0 || int'(max_length) > pmq_pkg::PAYLOAD_BYTES_DEF) ?
               pmq_pkg::PAYLOAD_BYTES_DEF : int'(max_length);
    slot = -1;
    if (req.command == pmq_pkg::CMD_SEND) begin
      // lowest free slot, unless the queue is at its cap
      if (held < cap_msgs) begin
        for (int i = 0; i < pmq_pkg::SLOTS_DEF; i++) begin
          if (!slot_used[i] && slot < 0) slot = i;
        end
      end
      if (slot < 0) begin
        res.status = pmq_pkg::STATUS_FULL;
      end else begin
        n = int'(req.length);
        if (n > cap_len) n = cap_len;
        slot_used[slot]  = 1'b1;
        slot_prio[slot]  = req.prio;
        slot_stamp[slot] = next_stamp;
        slot_len[slot]   = pmq_pkg::LEN_W'(n);
        slot_data[slot]  = keep_bytes(req.payload, n);
        next_stamp       = next_stamp + 1'b1;
        held++;
        res.length = pmq_pkg::LEN_W'(n);
      end
    end else begin
      // highest priority wins, oldest among equals
      best_age = '0;
      for (int i = 0; i < pmq_pkg::SLOTS_DEF; i++) begin
        if (slot_used[i]) begin
          age = next_stamp - slot_stamp[i];
          if (slot < 0 || slot_prio[i] > slot_prio[slot] ||
              (slot_prio[i] == slot_prio[slot] && age > best_age)) begin
            slot     = i;
            best_age = age;
          end
        end
      end
      if (slot < 0) begin
        res.status = pmq_pkg::STATUS_EMPTY;
      end else begin
        n = int'(slot_len[slot]);
        if (n > int'(req.limit)) n = int'(req.limit);
        res.length  = pmq_pkg::LEN_W'(n);
        res.payload = keep_bytes(slot_data[slot], n);
        res.prio    = slot_prio[slot];
        slot_used[slot] = 1'b0;
        if (held > 0) held--;
      end
    end
    res.count = pmq_pkg::COUNT_W'(held);
    due_results.push_back(res);
  endfunction

  function void compare(longint unsigned now, string field,
                        logic [pmq_pkg::DATA_W-1:0] want, logic [pmq_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0d ns: %s mismatch, expected %h actual %h", now, field, want, got);
    end
  endfunction

  // compare one accepted result beat against the oldest owed result
  function void check_result(result_t got, longint unsigned now);
    result_t want;
    if (due_results.size() == 0) begin
      errors++;
      $display("%0d ns: result beat with none outstanding, expected none, actual status %0d count %0d",
               now, got.status, got.count);
      return;
    end
    want = due_results.pop_front();
    compare(now, "status",        pmq_pkg::DATA_W'(want.status),
            pmq_pkg::DATA_W'(got.status));
    compare(now, "length_out",    pmq_pkg::DATA_W'(want.length),
            pmq_pkg::DATA_W'(got.length));
    compare(now, "payload_out",   want.payload, got.payload);
    compare(now, "priority_out",  pmq_pkg::DATA_W'(want.prio),
            pmq_pkg::DATA_W'(got.prio));
    compare(now, "message_count", pmq_pkg::DATA_W'(want.count),
            pmq_pkg::DATA_W'(got.count));
  endfunction
endclass

module priority_message_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 130;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [pmq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pmq_pkg::CFG_DATA_W-1:0] cfg_data;

  pmq_in_if  in_ch ();
  pmq_out_if out_ch ();

  priority_message_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pmq_scoreboard mirror = new();

  int idle_run      = 0;
  int results_seen  = 0;
  bit sender_steady   = 1'b0;
  bit receiver_steady = 1'b0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic request_t make_request(pmq_pkg::command_t cmd,
                                            logic [pmq_pkg::PRIO_W-1:0] p,
                                            logic [pmq_pkg::DATA_W-1:0] d, int len, int lim);
    request_t req;
    req.command = cmd;
    req.prio    = p;
    req.payload = d;
    req.length  = pmq_pkg::LEN_W'(len);
    req.limit   = pmq_pkg::LEN_W'(lim);
    return req;
  endfunction

  // random beat; priorities cluster on a few values so ties are common
  function automatic request_t random_request(int send_pct);
    pmq_pkg::command_t          cmd;
    logic [pmq_pkg::PRIO_W-1:0] p;
    int                         r;
    cmd = ($urandom_range(0, 99) < send_pct) ? pmq_pkg::CMD_SEND : pmq_pkg::CMD_RECV;
    r = $urandom_range(0, 9);
    if (r < 6)       p = $urandom_range(0, 3);
    else if (r < 8)  p = $urandom;
    else if (r == 8) p = '1;
    else             p = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFE : 32'h0;
    return make_request(cmd, p, {$urandom, $urandom}, $urandom_range(0, 8),
                        $urandom_range(0, 8));
  endfunction

  // drive one request beat, return at the edge it is taken
  task automatic offer(request_t req);
    int gap;
    gap = pick_gap(sender_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= req.command;
    in_ch.priority_req  <= req.prio;
    in_ch.payload_in    <= req.payload;
    in_ch.length_in     <= req.length;
    in_ch.receive_limit <= req.limit;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    mirror.note_request(req);
  endtask

  task automatic wait_drained();
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  // one write, then cfg_we is lowered before returning so back-to-back writes never collide
  task automatic set_register(pmq_pkg::cfg_index_t idx,
                              logic [pmq_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.write_reg(idx, data);
    @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off to back the queue up
  initial begin
    int      stall;
    bit      held_off;
    result_t got;
    held_off = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pick_gap(receiver_steady);
      if (results_seen == HOLD_AT && !held_off) begin
        stall    = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      got.status  = pmq_pkg::status_t'(out_ch.status);
      got.length  = out_ch.length_out;
      got.payload = out_ch.payload_out;
      got.prio    = out_ch.priority_out;
      got.count   = out_ch.message_count;
      mirror.check_result(got, $time);
      results_seen++;
      if (results_seen % 64 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle_run <= 0;
      end else if (idle_run + 1 >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // stimulus
  initial begin
    int                             send_pct;
    logic [pmq_pkg::CFG_DATA_W-1:0] msg_data;
    logic [pmq_pkg::CFG_DATA_W-1:0] len_data;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= pmq_pkg::CFG_MAX_MESSAGES;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= pmq_pkg::CMD_SEND;
    in_ch.priority_req  <= '0;
    in_ch.payload_in    <= '0;
    in_ch.length_in     <= '0;
    in_ch.receive_limit <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty receive, ties, zero length, receive limits
    offer(make_request(pmq_pkg::CMD_RECV, 32'h0, 64'h0, 0, 8));
    offer(make_request(pmq_pkg::CMD_SEND, 32'h0, '1, 8, 0));
    offer(make_request(pmq_pkg::CMD_SEND, '1, {$urandom, $urandom}, 0, 0));
    offer(make_request(pmq_pkg::CMD_SEND, 32'd5, 64'hFEDC_BA98_7654_3210, 3, 0));
    offer(make_request(pmq_pkg::CMD_SEND, 32'd5, 64'h0123_4567_89AB_CDEF, 8, 0));
    offer(make_request(pmq_pkg::CMD_SEND, 32'd5, {$urandom, $urandom}, 4, 0));
    offer(make_request(pmq_pkg::CMD_RECV, 32'h0, 64'h0, 0, 8));
    offer(make_request(pmq_pkg::CMD_RECV, 32'h0, 64'h0, 0, 0));
    offer(make_request(pmq_pkg::CMD_RECV, 32'h0, 64'h0, 0, 2));
    offer(make_request(pmq_pkg::CMD_RECV, 32'h0, 64'h0, 0, 8));
    offer(make_request(pmq_pkg::CMD_RECV, 32'h0, 64'h0, 0, 1));
    offer(make_request(pmq_pkg::CMD_RECV, 32'h0, 64'h0, 0, 8));
    in_ch.valid <= 1'b0;
    wait_drained();

    // tiny queue: truncation on send and full status
    set_register(pmq_pkg::CFG_MAX_MESSAGES, 5'd2);
    set_register(pmq_pkg::CFG_MAX_LENGTH, 5'd3);
    offer(make_request(pmq_pkg::CMD_SEND, 32'h8000_0000, '1, 8, 0));
    offer(make_request(pmq_pkg::CMD_SEND, 32'd1, 64'h5555_5555_AAAA_AAAA, 2, 0));
    offer(make_request(pmq_pkg::CMD_SEND, 32'd7, {$urandom, $urandom}, 1, 0));
    offer(make_request(pmq_pkg::CMD_RECV, 32'h0, 64'h0, 0, 8));
    offer(make_request(pmq_pkg::CMD_RECV, 32'h0, 64'h0, 0, 8));
    offer(make_request(pmq_pkg::CMD_RECV, 32'h0, 64'h0, 0, 8));

    // random phases, each under its own settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      in_ch.valid <= 1'b0;
      wait_drained();
      case (phase)
        0:       begin msg_data = 5'd16; len_data = 5'd8;  end
        1:       begin msg_data = 5'd1;  len_data = 5'd1;  end
        2:       begin msg_data = 5'd0;  len_data = 5'd0;  end
        3:       begin msg_data = 5'd31; len_data = 5'd31; end
        4:       begin msg_data = 5'd17; len_data = 5'd9;  end
        5:       begin msg_data = 5'd5;  len_data = 5'd3;  end
        6:       begin
          msg_data = pmq_pkg::CFG_DATA_W'($urandom_range(1, 16));
          len_data = pmq_pkg::CFG_DATA_W'($urandom_range(1, 8));
        end
        default: begin msg_data = 5'd2;  len_data = 5'd8;  end
      endcase
      set_register(pmq_pkg::CFG_MAX_MESSAGES, msg_data);
      set_register(pmq_pkg::CFG_MAX_LENGTH, len_data);
      sender_steady = ($urandom_range(0, 3) == 0);
      send_pct = 50;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // swing between filling and draining so both ends are reached
        if (k % 20 == 0) begin
          case ($urandom_range(0, 2))
            0:       send_pct = 25;
            1:       send_pct = 50;
            default: send_pct = 75;
          endcase
        end
        offer(random_request(send_pct));
      end
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
